### hdl/utt_pkg.sv
// Shared types, constants and encode helpers for the UTF-16/UTF-32 to UTF-8 transcoder.
`timescale 1ns / 1ps

package utt_pkg;

	localparam int unsigned UNIT_W      = 21;
	localparam int unsigned MAX_RESULTS = 4;
	localparam int unsigned RES_IDX_W   = $clog2(MAX_RESULTS);

	localparam logic [UNIT_W-1:0] HIGH_FIRST = 21'h00D800;
	localparam logic [UNIT_W-1:0] HIGH_LAST  = 21'h00DBFF;
	localparam logic [UNIT_W-1:0] LOW_FIRST  = 21'h00DC00;
	localparam logic [UNIT_W-1:0] LOW_LAST   = 21'h00DFFF;
	localparam logic [UNIT_W-1:0] BMP_MAX    = 21'h00FFFF;
	localparam logic [UNIT_W-1:0] SUPP_BASE  = 21'h010000;
	localparam logic [UNIT_W-1:0] CP_MAX     = 21'h10FFFF;

	// configuration register map (word index)
	localparam int unsigned REG_IDX_W = 1;
	localparam logic [REG_IDX_W-1:0] REG_UTF16_MODE = 1'b0;
	localparam logic UTF16_MODE_RESET = 1'b1;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NO_HIGH  = 2'd1,
		ST_NO_LOW   = 2'd2,
		ST_RANGE    = 2'd3
	} status_t;

	typedef struct packed {
		logic [7:0] out_byte;
		status_t    status;
		logic       last_of_run;
		logic       end_of_string;
	} result_t;

	// all results caused by one input unit; res[0] goes out first
	typedef struct packed {
		result_t [MAX_RESULTS-1:0] res;
		logic [RES_IDX_W-1:0]      last_idx;
	} job_t;

	function automatic result_t data_byte(logic [7:0] b, logic last);
		result_t r;
		r.out_byte      = b;
		r.status        = ST_OK;
		r.last_of_run   = last;
		r.end_of_string = 1'b0;
		return r;
	endfunction

	function automatic result_t err_result(status_t st, logic last);
		result_t r;
		r.out_byte      = 8'h00;
		r.status        = st;
		r.last_of_run   = last;
		r.end_of_string = 1'b0;
		return r;
	endfunction

	function automatic result_t term_result();
		result_t r;
		r.out_byte      = 8'h00;
		r.status        = ST_OK;
		r.last_of_run   = 1'b1;
		r.end_of_string = 1'b1;
		return r;
	endfunction

	function automatic job_t single_job(result_t r);
		job_t j;
		j = '0;
		j.res[0]   = r;
		j.last_idx = '0;
		return j;
	endfunction

	function automatic job_t utf8_encode(logic [UNIT_W-1:0] cp);
		job_t j;
		j = '0;
		if (cp < 21'h000080) begin
			j.res[0]   = data_byte({1'b0, cp[6:0]}, 1'b1);
			j.last_idx = RES_IDX_W'(0);
		end else if (cp < 21'h000800) begin
			j.res[0]   = data_byte({3'b110, cp[10:6]}, 1'b0);
			j.res[1]   = data_byte({2'b10, cp[5:0]}, 1'b1);
			j.last_idx = RES_IDX_W'(1);
		end else if (cp < SUPP_BASE) begin
			j.res[0]   = data_byte({4'b1110, cp[15:12]}, 1'b0);
			j.res[1]   = data_byte({2'b10, cp[11:6]}, 1'b0);
			j.res[2]   = data_byte({2'b10, cp[5:0]}, 1'b1);
			j.last_idx = RES_IDX_W'(2);
		end else begin
			j.res[0]   = data_byte({5'b11110, cp[20:18]}, 1'b0);
			j.res[1]   = data_byte({2'b10, cp[17:12]}, 1'b0);
			j.res[2]   = data_byte({2'b10, cp[11:6]}, 1'b0);
			j.res[3]   = data_byte({2'b10, cp[5:0]}, 1'b1);
			j.last_idx = RES_IDX_W'(3);
		end
		return j;
	endfunction

endpackage

### hdl/utf16_to_utf8_transcoder.sv
// A unit's first byte goes through the job queue, job register and output register.
// Throughput: one result byte per cycle out of the serializer while pop keeps up; a unit
// gives 1 to 4 bytes (up to 3 for a BMP character), a held high surrogate or dropped unit none.
// The front end takes one unit per cycle until the job queue (QUEUE_DEPTH entries) fills.
// Reset (arst_n low, asynchronous) clears the queue, the surrogate and drop state, and
// sets utf16_mode to 1.
`timescale 1ns / 1ps

module utf16_to_utf8_transcoder #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// input units
	input  logic                       push,
	output logic                       full,
	input  logic [utt_pkg::UNIT_W-1:0] code_unit,
	// result bytes
	input  logic                       pop,
	output logic                       empty,
	output logic [7:0]                 out_byte,
	output logic [1:0]                 status,
	output logic                       last_of_run,
	output logic                       end_of_string,
	// configuration
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [2:0]                 paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready
);

	logic             utf16_mode_q;
	logic             q_wr;
	logic             q_full;
	logic             q_rd;
	logic             q_empty;
	utt_pkg::job_t    q_wr_data;
	utt_pkg::job_t    q_rd_data;
	utt_pkg::result_t result;

	logic [utt_pkg::REG_IDX_W-1:0] reg_idx;
	logic                          cfg_wr;

	assign pready  = 1'b1;
	assign reg_idx = paddr[2];
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign prdata  = (reg_idx == utt_pkg::REG_UTF16_MODE) ? {31'b0, utf16_mode_q} : 32'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			utf16_mode_q <= utt_pkg::UTF16_MODE_RESET;
		end else if (cfg_wr && (reg_idx == utt_pkg::REG_UTF16_MODE)) begin
			utf16_mode_q <= pwdata[0];
		end
	end

	assign full = q_full;

	utt_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.code_unit  (code_unit),
		.utf16_mode (utf16_mode_q),
		.q_full     (q_full),
		.job_wr     (q_wr),
		.job        (q_wr_data)
	);

	utt_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_wr),
		.wr_data (q_wr_data),
		.full    (q_full),
		.rd_en   (q_rd),
		.rd_data (q_rd_data),
		.empty   (q_empty)
	);

	utt_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_data  (q_rd_data),
		.q_rd    (q_rd),
		.pop     (pop),
		.empty   (empty),
		.result  (result)
	);

	assign out_byte      = result.out_byte;
	assign status        = result.status;
	assign last_of_run   = result.last_of_run;
	assign end_of_string = result.end_of_string;

`ifndef NO_ASSERTIONS
	a_no_write_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_wr |-> !q_full)
		else $error("job written into a full queue");

	a_terminator_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && end_of_string) |-> (last_of_run && status == utt_pkg::ST_OK
			&& out_byte == 8'h00))
		else $error("terminator result is malformed");

	a_error_zero_byte: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status != utt_pkg::ST_OK) |-> (out_byte == 8'h00 && !end_of_string))
		else $error("error result carries a data byte");

	a_dequeue_needs_data: assert property (@(posedge clk) disable iff (!arst_n)
		q_rd |-> !q_empty)
		else $error("serializer read from an empty queue");
`endif

endmodule

### hdl/utt_front.sv
// Front end: accepts code units, tracks surrogate and error state, builds result jobs.
`timescale 1ns / 1ps

module utt_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	input  logic [utt_pkg::UNIT_W-1:0]   code_unit,
	input  logic                         utf16_mode,
	input  logic                         q_full,
	output logic                         job_wr,
	output utt_pkg::job_t                job
);

	logic       pending_valid_q;
	logic [9:0] pending_high_q;
	logic       dropping_q;

	logic       accept;
	logic       has_job;
	logic       pending_valid_d;
	logic [9:0] pending_high_d;
	logic       dropping_d;

	assign accept = push && !q_full;
	assign job_wr = accept && has_job;

	always_comb begin
		logic                       is_high;
		logic                       is_low;
		logic [utt_pkg::UNIT_W-1:0] cp;
		is_high = (code_unit >= utt_pkg::HIGH_FIRST) && (code_unit <= utt_pkg::HIGH_LAST);
		is_low  = (code_unit >= utt_pkg::LOW_FIRST) && (code_unit <= utt_pkg::LOW_LAST);
		cp      = {1'b0, pending_high_q, code_unit[9:0]} + utt_pkg::SUPP_BASE;

		has_job         = 1'b0;
		job             = '0;
		pending_valid_d = pending_valid_q;
		pending_high_d  = pending_high_q;
		dropping_d      = dropping_q;

		if (code_unit == '0) begin
			// terminator; an unfinished pair reports first
			has_job = 1'b1;
			if (pending_valid_q && !dropping_q) begin
				job          = '0;
				job.res[0]   = utt_pkg::err_result(utt_pkg::ST_NO_LOW, 1'b0);
				job.res[1]   = utt_pkg::term_result();
				job.last_idx = utt_pkg::RES_IDX_W'(1);
			end else begin
				job = utt_pkg::single_job(utt_pkg::term_result());
			end
			pending_valid_d = 1'b0;
			pending_high_d  = '0;
			dropping_d      = 1'b0;
		end else if (dropping_q) begin
			has_job = 1'b0;
		end else if (pending_valid_q) begin
			has_job         = 1'b1;
			pending_valid_d = 1'b0;
			pending_high_d  = '0;
			if (utf16_mode && is_low) begin
				job = utt_pkg::utf8_encode(cp);
			end else begin
				job        = utt_pkg::single_job(utt_pkg::err_result(utt_pkg::ST_NO_LOW, 1'b1));
				dropping_d = 1'b1;
			end
		end else if (utf16_mode) begin
			if (code_unit > utt_pkg::BMP_MAX) begin
				has_job    = 1'b1;
				job        = utt_pkg::single_job(utt_pkg::err_result(utt_pkg::ST_RANGE, 1'b1));
				dropping_d = 1'b1;
			end else if (is_low) begin
				has_job    = 1'b1;
				job        = utt_pkg::single_job(utt_pkg::err_result(utt_pkg::ST_NO_HIGH, 1'b1));
				dropping_d = 1'b1;
			end else if (is_high) begin
				// hold the high half until its partner arrives
				pending_valid_d = 1'b1;
				pending_high_d  = code_unit[9:0];
			end else begin
				has_job = 1'b1;
				job     = utt_pkg::utf8_encode(code_unit);
			end
		end else begin
			has_job = 1'b1;
			if (code_unit > utt_pkg::CP_MAX) begin
				job        = utt_pkg::single_job(utt_pkg::err_result(utt_pkg::ST_RANGE, 1'b1));
				dropping_d = 1'b1;
			end else begin
				job = utt_pkg::utf8_encode(code_unit);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_valid_q <= 1'b0;
			pending_high_q  <= '0;
			dropping_q      <= 1'b0;
		end else if (accept) begin
			pending_valid_q <= pending_valid_d;
			pending_high_q  <= pending_high_d;
			dropping_q      <= dropping_d;
		end
	end

endmodule

### hdl/utt_queue.sv
// Job queue between the front end and the byte serializer.
`timescale 1ns / 1ps

module utt_queue #(
	parameter int unsigned DEPTH = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  utt_pkg::job_t wr_data,
	output logic          full,
	input  logic          rd_en,
	output utt_pkg::job_t rd_data,
	output logic          empty
);

	localparam int unsigned PTR_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	utt_pkg::job_t    entries_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	logic do_wr;
	logic do_rd;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			entries_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### hdl/utt_back.sv
// Back end: turns a job into bytes via an output register, one per cycle unless pop stalls.
`timescale 1ns / 1ps

module utt_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_empty,
	input  utt_pkg::job_t   q_data,
	output logic            q_rd,
	input  logic            pop,
	output logic            empty,
	output utt_pkg::result_t result
);

	utt_pkg::job_t                  job_q;
	logic                           job_valid_q;
	logic [utt_pkg::RES_IDX_W-1:0]  idx_q;
	utt_pkg::result_t               out_q;
	logic                           out_valid_q;

	logic out_ready;
	logic emit;
	logic job_done;

	assign out_ready = !out_valid_q || pop;
	assign emit      = job_valid_q && out_ready;
	assign job_done  = emit && (idx_q == job_q.last_idx);
	// fetch the next job as soon as the current one hands out its last byte
	assign q_rd      = !q_empty && (!job_valid_q || job_done);

	assign empty  = !out_valid_q;
	assign result = out_q;

	always_ff @(posedge clk) begin
		if (q_rd) begin
			job_q <= q_data;
		end
		if (emit) begin
			out_q <= job_q.res[idx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_valid_q <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_rd) begin
				job_valid_q <= 1'b1;
				idx_q       <= '0;
			end else if (job_done) begin
				job_valid_q <= 1'b0;
			end else if (emit) begin
				idx_q <= idx_q + 1'b1;
			end

			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

### test/utf8_byte_checker.sv
// Checker for the transcoder: predicts UTF-8 result bytes from accepted units and compares them.
`timescale 1ns / 1ps

module utf8_byte_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  logic                       full,
	input  logic [utt_pkg::UNIT_W-1:0] code_unit,
	input  logic                       pop,
	input  logic                       empty,
	input  logic [7:0]                 out_byte,
	input  logic [1:0]                 status,
	input  logic                       last_of_run,
	input  logic                       end_of_string,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic                       pready,
	input  logic [2:0]                 paddr,
	input  logic [31:0]                pwdata,
	output int                         mismatches,
	output int                         outstanding,
	output int                         bytes_checked
);

	localparam logic [2:0] MODE_ADDR = {utt_pkg::REG_UTF16_MODE, 2'b00};

	utt_pkg::result_t utf8_due[$];
	logic             utf16_mode;
	logic [9:0]       held_high;
	logic             held_valid;
	logic             dropping;

	initial begin
		mismatches    = 0;
		bytes_checked = 0;
	end

	task automatic expect_byte(input logic [7:0] b, input utt_pkg::status_t st,
			input logic last, input logic eos);
		utt_pkg::result_t r;
		r.out_byte      = b;
		r.status        = st;
		r.last_of_run   = last;
		r.end_of_string = eos;
		utf8_due.push_back(r);
	endtask

	task automatic flag_error(input utt_pkg::status_t st);
		expect_byte(8'h00, st, 1'b1, 1'b0);
		dropping   = 1'b1;
		held_valid = 1'b0;
		held_high  = '0;
	endtask

	task automatic emit_code_point(input logic [utt_pkg::UNIT_W-1:0] cp);
		if (cp < 21'h80) begin
			expect_byte({1'b0, cp[6:0]}, utt_pkg::ST_OK, 1'b1, 1'b0);
		end else if (cp < 21'h800) begin
			expect_byte({3'b110, cp[10:6]}, utt_pkg::ST_OK, 1'b0, 1'b0);
			expect_byte({2'b10, cp[5:0]}, utt_pkg::ST_OK, 1'b1, 1'b0);
		end else if (cp < utt_pkg::SUPP_BASE) begin
			expect_byte({4'b1110, cp[15:12]}, utt_pkg::ST_OK, 1'b0, 1'b0);
			expect_byte({2'b10, cp[11:6]}, utt_pkg::ST_OK, 1'b0, 1'b0);
			expect_byte({2'b10, cp[5:0]}, utt_pkg::ST_OK, 1'b1, 1'b0);
		end else begin
			expect_byte({5'b11110, cp[20:18]}, utt_pkg::ST_OK, 1'b0, 1'b0);
			expect_byte({2'b10, cp[17:12]}, utt_pkg::ST_OK, 1'b0, 1'b0);
			expect_byte({2'b10, cp[11:6]}, utt_pkg::ST_OK, 1'b0, 1'b0);
			expect_byte({2'b10, cp[5:0]}, utt_pkg::ST_OK, 1'b1, 1'b0);
		end
	endtask

	task automatic transcode_unit(input logic [utt_pkg::UNIT_W-1:0] u);
		logic                       is_high;
		logic                       is_low;
		logic [utt_pkg::UNIT_W-1:0] cp;
		is_high = (u >= utt_pkg::HIGH_FIRST) && (u <= utt_pkg::HIGH_LAST);
		is_low  = (u >= utt_pkg::LOW_FIRST) && (u <= utt_pkg::LOW_LAST);
		if (u == '0) begin
			// a held high surrogate is reported before the terminator
			if (held_valid && !dropping)
				expect_byte(8'h00, utt_pkg::ST_NO_LOW, 1'b0, 1'b0);
			expect_byte(8'h00, utt_pkg::ST_OK, 1'b1, 1'b1);
			held_valid = 1'b0;
			held_high  = '0;
			dropping   = 1'b0;
		end else if (!dropping) begin
			if (held_valid) begin
				if (utf16_mode && is_low) begin
					cp = (utt_pkg::UNIT_W'(held_high) << 10) + (u - utt_pkg::LOW_FIRST)
						+ utt_pkg::SUPP_BASE;
					held_valid = 1'b0;
					held_high  = '0;
					emit_code_point(cp);
				end else begin
					flag_error(utt_pkg::ST_NO_LOW);
				end
			end else if (utf16_mode) begin
				if (u > utt_pkg::BMP_MAX) flag_error(utt_pkg::ST_RANGE);
				else if (is_low) flag_error(utt_pkg::ST_NO_HIGH);
				else if (is_high) begin
					held_high  = u[9:0];
					held_valid = 1'b1;
				end else emit_code_point(u);
			end else if (u > utt_pkg::CP_MAX) begin
				flag_error(utt_pkg::ST_RANGE);
			end else begin
				emit_code_point(u);
			end
		end
	endtask

	task automatic check_byte();
		utt_pkg::result_t e;
		if (utf8_due.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: unexpected byte %h status %0d last %b eos %b", $realtime,
					out_byte, status, last_of_run, end_of_string);
		end else begin
			e = utf8_due.pop_front();
			bytes_checked++;
			if (out_byte !== e.out_byte || status !== e.status ||
					last_of_run !== e.last_of_run || end_of_string !== e.end_of_string) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: byte %h status %0d last %b eos %b, expected %h %0d %b %b",
						$realtime, out_byte, status, last_of_run, end_of_string,
						e.out_byte, e.status, e.last_of_run, e.end_of_string);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			utf8_due.delete();
			utf16_mode  = utt_pkg::UTF16_MODE_RESET;
			held_high   = '0;
			held_valid  = 1'b0;
			dropping    = 1'b0;
			outstanding <= 0;
		end else begin
			if (pop && !empty)
				check_byte();
			if (psel && penable && pwrite && pready && paddr == MODE_ADDR)
				utf16_mode = pwdata[0];
			if (push && !full)
				transcode_unit(code_unit);
			outstanding <= utf8_due.size();
		end
	end

endmodule

### test/testbench.sv
// Top of the transcoder test: clock, reset, unit and register stimulus, result drain, verdict.
`timescale 1ns / 1ps

module testbench;

	localparam logic [2:0] MODE_ADDR = {utt_pkg::REG_UTF16_MODE, 2'b00};

	logic                       clk;
	logic                       arst_n;
	logic                       push;
	logic                       full;
	logic [utt_pkg::UNIT_W-1:0] code_unit;
	logic                       pop;
	logic                       empty;
	logic [7:0]                 out_byte;
	logic [1:0]                 status;
	logic                       last_of_run;
	logic                       end_of_string;
	logic                       psel;
	logic                       penable;
	logic                       pwrite;
	logic [2:0]                 paddr;
	logic [31:0]                pwdata;
	logic [31:0]                prdata;
	logic                       pready;

	int mismatches;
	int outstanding;
	int bytes_checked;

	bit steady;
	bit hold_off;
	int units_sent;
	int useful_units;
	int strings_sent;
	int broken_strings;
	int mode_writes;

	utf16_to_utf8_transcoder u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.code_unit     (code_unit),
		.pop           (pop),
		.empty         (empty),
		.out_byte      (out_byte),
		.status        (status),
		.last_of_run   (last_of_run),
		.end_of_string (end_of_string),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	utf8_byte_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.code_unit     (code_unit),
		.pop           (pop),
		.empty         (empty),
		.out_byte      (out_byte),
		.status        (status),
		.last_of_run   (last_of_run),
		.end_of_string (end_of_string),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.pready        (pready),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.mismatches    (mismatches),
		.outstanding   (outstanding),
		.bytes_checked (bytes_checked)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#3_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	// result side: random pop gaps, plus one long hold-off on request
	initial begin
		int gap;
		pop <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_off) begin
				pop <= 1'b0;
				repeat (150) @(posedge clk);
				hold_off = 1'b0;
			end
			gap = steady ? 0 : $urandom_range(0, 10);
			if (gap > 0) begin
				pop <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty);
		end
	end

	function automatic logic [utt_pkg::UNIT_W-1:0] rand_unit(
			input logic [utt_pkg::UNIT_W-1:0] lo, input logic [utt_pkg::UNIT_W-1:0] hi);
		return utt_pkg::UNIT_W'($urandom_range(32'(hi), 32'(lo)));
	endfunction

	task automatic send_unit(input logic [utt_pkg::UNIT_W-1:0] u, input bit counts = 1'b1);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push      <= 1'b1;
		code_unit <= u;
		do @(posedge clk); while (full);
		units_sent++;
		if (counts) useful_units++;
	endtask

	// drain every expected byte, then allow for units that produce nothing
	task automatic settle();
		push <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_mode(input logic m);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= MODE_ADDR;
		pwdata  <= {31'($urandom), m};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		mode_writes++;
	endtask

	task automatic send_string(input bit utf16);
		int                         len;
		int                         pick;
		bit                         broken;
		bit                         hold_to_end;
		logic [utt_pkg::UNIT_W-1:0] cp;
		logic [utt_pkg::UNIT_W-1:0] offs;
		len         = $urandom_range(0, 8);
		broken      = 1'b0;
		hold_to_end = 1'b0;
		for (int i = 0; i < len && !broken; i++) begin
			if ($urandom_range(0, 99) < 7) begin
				broken = 1'b1;
				broken_strings++;
				if (!utf16) begin
					send_unit(rand_unit(utt_pkg::CP_MAX + 21'd1, 21'h1FFFFF));
				end else begin
					pick = $urandom_range(0, 4);
					case (pick)
						0: send_unit(rand_unit(utt_pkg::LOW_FIRST, utt_pkg::LOW_LAST));
						1: begin
							send_unit(rand_unit(utt_pkg::HIGH_FIRST, utt_pkg::HIGH_LAST));
							send_unit(rand_unit(21'd1, utt_pkg::HIGH_LAST));
						end
						2: send_unit(rand_unit(utt_pkg::SUPP_BASE, 21'h1FFFFF));
						3: begin
							// high surrogate runs into the terminator
							send_unit(rand_unit(utt_pkg::HIGH_FIRST, utt_pkg::HIGH_LAST));
							hold_to_end = 1'b1;
						end
						default: begin
							send_unit(rand_unit(utt_pkg::HIGH_FIRST, utt_pkg::HIGH_LAST));
							send_unit(rand_unit(utt_pkg::SUPP_BASE, 21'h1FFFFF));
						end
					endcase
				end
				if (!hold_to_end)
					repeat ($urandom_range(0, 3)) send_unit(rand_unit(21'd1, 21'h1FFFFF), 1'b0);
			end else begin
				pick = $urandom_range(0, 3);
				case (pick)
					0: cp = rand_unit(21'd1, 21'h7F);
					1: cp = rand_unit(21'h80, 21'h7FF);
					2: begin
						if (!utf16) cp = rand_unit(21'h800, utt_pkg::BMP_MAX);
						else if ($urandom_range(0, 1))
							cp = rand_unit(21'h800, utt_pkg::HIGH_FIRST - 21'd1);
						else cp = rand_unit(utt_pkg::LOW_LAST + 21'd1, utt_pkg::BMP_MAX);
					end
					default: cp = rand_unit(utt_pkg::SUPP_BASE, utt_pkg::CP_MAX);
				endcase
				if (utf16 && cp >= utt_pkg::SUPP_BASE) begin
					offs = cp - utt_pkg::SUPP_BASE;
					send_unit(utt_pkg::HIGH_FIRST + {11'd0, offs[19:10]});
					send_unit(utt_pkg::LOW_FIRST + {11'd0, offs[9:0]});
				end else begin
					send_unit(cp);
				end
			end
		end
		send_unit('0);
		strings_sent++;
	endtask

	initial begin
		arst_n    <= 1'b0;
		push      <= 1'b0;
		code_unit <= '0;
		psel      <= 1'b0;
		penable   <= 1'b0;
		pwrite    <= 1'b0;
		paddr     <= '0;
		pwdata    <= '0;
		steady         = 1'b0;
		hold_off       = 1'b0;
		units_sent     = 0;
		useful_units   = 0;
		strings_sent   = 0;
		broken_strings = 0;
		mode_writes    = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// UTF-16 after reset: encoding length boundaries and both surrogate pair extremes
		send_unit(21'h41);
		send_unit(21'h80);
		send_unit(21'h7FF);
		send_unit(21'h800);
		send_unit(utt_pkg::BMP_MAX);
		send_unit(utt_pkg::HIGH_FIRST);
		send_unit(utt_pkg::LOW_FIRST);
		send_unit(utt_pkg::HIGH_LAST);
		send_unit(utt_pkg::LOW_LAST);
		send_unit('0);
		// lone low surrogate, then a dropped unit with every bit set
		send_unit(utt_pkg::LOW_FIRST);
		send_unit(21'h1FFFFF, 1'b0);
		send_unit('0);
		// high surrogate followed by a plain character
		send_unit(utt_pkg::HIGH_FIRST);
		send_unit(21'h41);
		send_unit('0);
		// unit too wide for UTF-16
		send_unit(utt_pkg::SUPP_BASE);
		send_unit('0);
		// high surrogate directly before the terminator
		send_unit(utt_pkg::HIGH_LAST);
		send_unit('0);
		// high surrogate held across a switch to UTF-32
		send_unit(utt_pkg::HIGH_FIRST);
		settle();
		write_mode(1'b0);
		send_unit(21'h41);
		send_unit('0);
		// UTF-32: top code point, raw surrogate value, first value out of range
		send_unit(utt_pkg::CP_MAX);
		send_unit(utt_pkg::LOW_FIRST);
		send_unit(utt_pkg::CP_MAX + 21'd1);
		send_unit('0);
		settle();

		for (int ph = 0; ph < 6; ph++) begin
			write_mode(ph % 2 == 0);
			if (ph == 2) begin
				// stall the result side while units keep coming
				steady   = 1'b1;
				hold_off = 1'b1;
				repeat (10) send_string(1'b1);
				steady = 1'b0;
			end
			while (useful_units < 30 + (ph + 1) * 67) begin
				steady = ($urandom_range(0, 99) < 15);
				send_string(ph % 2 == 0);
			end
			steady = 1'b0;
			settle();
		end

		$display("Sent %0d code units in %0d strings (%0d broken) over %0d mode writes;",
			units_sent, strings_sent, broken_strings, mode_writes);
		$display("checked %0d UTF-8 result bytes, %0d mismatches.", bytes_checked, mismatches);
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
